### design/pfa_pkg.sv
// Shared constants and types for the page frame allocator.
`timescale 1ns / 1ps
package pfa_pkg;

  localparam int NPAGES_DEF     = 32768;
  localparam int LABEL_BITS_DEF = 8;

  localparam int OP_W       = 3;
  localparam int PAGE_W     = 16;
  localparam int LBL_W      = 8;
  localparam int FPAGE_W    = 15;
  localparam int RC_W       = 16;
  localparam int CNT_OUT_W  = 16;
  localparam int STS_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int WIDE_W     = 17;
  localparam int SUM_W      = 18;

  localparam logic [RC_W-1:0] RC_MAX = '1;

  localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
  localparam logic [OP_W-1:0] OP_INCREF    = 3'd2;
  localparam logic [OP_W-1:0] OP_GET_LABEL = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_LABEL = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FREE_START    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_LABEL = 2'd2;

  localparam logic [FPAGE_W-1:0] FREE_START_RST    = 15'd256;
  localparam logic [FPAGE_W-1:0] KERNEL_END_RST    = 15'd0;
  localparam logic [LBL_W-1:0]   DEFAULT_LABEL_RST = 8'd0;

  typedef enum logic [STS_W-1:0] {
    STS_OK          = 2'd0,
    STS_OOM         = 2'd1,
    STS_BAD_ADDR    = 2'd2,
    STS_DOUBLE_FREE = 2'd3
  } status_t;

endpackage

### design/pfa_in_if.sv
// Request channel: operation, page and label.
`timescale 1ns / 1ps
interface pfa_in_if;
  logic                        valid;
  logic                        ready;
  logic [pfa_pkg::OP_W-1:0]    op;
  logic [pfa_pkg::PAGE_W-1:0]  page;
  logic [pfa_pkg::LBL_W-1:0]   wr_label;

  modport source(output valid, op, page, wr_label, input ready);
  modport sink(input valid, op, page, wr_label, output ready);
endinterface

### design/pfa_out_if.sv
// Response channel: status, allocated page, label, count and free count.
`timescale 1ns / 1ps
interface pfa_out_if;
  logic                          valid;
  logic                          ready;
  pfa_pkg::status_t              status;
  logic [pfa_pkg::FPAGE_W-1:0]   alloc_page;
  logic [pfa_pkg::LBL_W-1:0]     label_out;
  logic [pfa_pkg::RC_W-1:0]      ref_count_out;
  logic [pfa_pkg::CNT_OUT_W-1:0] free_count;

  modport source(output valid, status, alloc_page, label_out, ref_count_out, free_count,
                 input ready);
  modport sink(input valid, status, alloc_page, label_out, ref_count_out, free_count,
               output ready);
endinterface

### design/pfa_cfg_if.sv
// Configuration write channel: register index and data.
`timescale 1ns / 1ps
interface pfa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pfa_pkg::CFG_IDX_W-1:0]    index;
  logic [pfa_pkg::CFG_DATA_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### design/page_frame_allocator_refcount.sv
// Page frame allocator with LIFO free stack, per-page refcount and label.
// Result: executed in ST_EXEC and then registered; waits while a response is held.
// One request at a time: each reads, then writes the per-page memory.
// Reset: a clearing pass over every entry zeroes the per-page memory; requests wait,
// configuration writes are taken throughout.
// next_free memory is not cleared; only entries written by a free are read.
`timescale 1ns / 1ps
module page_frame_allocator_refcount #(
  parameter int NPAGES     = pfa_pkg::NPAGES_DEF,
  parameter int LABEL_BITS = pfa_pkg::LABEL_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  pfa_in_if.sink        in_ch,
  pfa_out_if.source     out_ch,
  pfa_cfg_if.sink       cfg_ch
);

  localparam int AW = $clog2(NPAGES);
  localparam int SW = $clog2(NPAGES + 1);
  localparam int RW = pfa_pkg::RC_W;
  localparam int MW = 1 + LABEL_BITS + RW;
  localparam int WW = pfa_pkg::WIDE_W;
  localparam int CW = pfa_pkg::SUM_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NPAGES - 1);
  localparam logic [WW-1:0] NPAGES_W  = WW'(NPAGES);
  localparam logic [SW-1:0] NPAGES_S  = SW'(NPAGES);
  localparam logic [CW-1:0] CNT_SAT   = CW'(65535);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [MW-1:0] meta_mem_r [NPAGES];
  logic [AW-1:0] nf_mem_r   [NPAGES];
  logic [MW-1:0] meta_q_r;
  logic [AW-1:0] nf_q_r;

  logic [AW-1:0] clr_addr_r;

  logic [pfa_pkg::FPAGE_W-1:0] free_start_r;
  logic [pfa_pkg::FPAGE_W-1:0] kernel_end_r;
  logic [pfa_pkg::LBL_W-1:0]   default_label_r;

  logic [AW-1:0] stack_head_r, stack_head_nxt;
  logic [SW-1:0] stacked_r, stacked_nxt;
  logic [AW-1:0] watermark_r, watermark_nxt;
  logic          region_valid_r, region_valid_nxt;

  logic [pfa_pkg::OP_W-1:0]   op_r;
  logic [pfa_pkg::PAGE_W-1:0] page_r;
  logic [pfa_pkg::LBL_W-1:0]  nl_r;
  logic [AW-1:0]              addr_r;
  logic [CW-1:0]              cnt_r;

  logic                            out_valid_r;
  pfa_pkg::status_t                out_status_r;
  logic [pfa_pkg::FPAGE_W-1:0]     out_alloc_page_r;
  logic [pfa_pkg::LBL_W-1:0]       out_label_r;
  logic [RW-1:0]                   out_rc_r;
  logic [pfa_pkg::CNT_OUT_W-1:0]   out_free_count_r;

  logic          accept;
  logic          exec_go;
  logic [AW-1:0] rd_addr;
  logic [WW-1:0] fs_w, wm_w, pg_w, ke_w;
  logic          region_ne;
  logic [CW-1:0] cnt_before;

  logic          meta_freed;
  logic [LABEL_BITS-1:0] meta_lab;
  logic [RW-1:0] meta_rc;
  logic [RW-1:0] rc_dec;
  logic [31:0]   dl_w, nl_w, lab_w;
  logic [LABEL_BITS-1:0] dl_lbl;

  pfa_pkg::status_t      sts;
  logic [AW-1:0]         got;
  logic [LABEL_BITS-1:0] lab;
  logic [RW-1:0]         rc;
  logic                  cnt_inc, cnt_dec;
  logic                  meta_we_op;
  logic [MW-1:0]         meta_wdata_op;
  logic                  nf_we_op;

  logic          meta_we;
  logic [AW-1:0] meta_waddr;
  logic [MW-1:0] meta_wdata;
  logic          nf_we;
  logic [CW-1:0] cnt_after;
  logic [15:0]   got_w;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign accept       = in_ch.valid && (state_r == ST_IDLE);
  assign exec_go      = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);

  assign fs_w = WW'(free_start_r);
  assign wm_w = WW'(watermark_r);
  assign ke_w = WW'(kernel_end_r);
  assign pg_w = WW'(page_r);

  assign region_ne  = region_valid_r && (wm_w >= fs_w);
  assign cnt_before = CW'(stacked_r) + (region_ne ? CW'(wm_w - fs_w) + CW'(1) : '0);

  // hold the read address while a request waits in execute
  always_comb begin
    if (state_r == ST_EXEC) begin
      rd_addr = addr_r;
    end else if (in_ch.op == pfa_pkg::OP_ALLOC) begin
      rd_addr = (stacked_r != '0) ? stack_head_r : watermark_r;
    end else begin
      rd_addr = in_ch.page[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_start_r    <= pfa_pkg::FREE_START_RST;
      kernel_end_r    <= pfa_pkg::KERNEL_END_RST;
      default_label_r <= pfa_pkg::DEFAULT_LABEL_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        pfa_pkg::REG_FREE_START:    free_start_r    <= cfg_ch.data;
        pfa_pkg::REG_KERNEL_END:    kernel_end_r    <= cfg_ch.data;
        pfa_pkg::REG_DEFAULT_LABEL: default_label_r <= cfg_ch.data[pfa_pkg::LBL_W-1:0];
        default: ;
      endcase
    end
  end

  assign meta_freed = meta_q_r[MW-1];
  assign meta_lab   = meta_q_r[RW +: LABEL_BITS];
  assign meta_rc    = meta_q_r[RW-1:0];
  assign rc_dec     = (meta_rc != '0) ? meta_rc - RW'(1) : '0;
  assign dl_w       = 32'(default_label_r);
  assign nl_w       = 32'(nl_r);
  assign dl_lbl     = dl_w[LABEL_BITS-1:0];

  always_comb begin
    sts              = pfa_pkg::STS_OK;
    got              = '0;
    lab              = '0;
    rc               = '0;
    cnt_inc          = 1'b0;
    cnt_dec          = 1'b0;
    meta_we_op       = 1'b0;
    meta_wdata_op    = meta_q_r;
    nf_we_op         = 1'b0;
    stack_head_nxt   = stack_head_r;
    stacked_nxt      = stacked_r;
    watermark_nxt    = watermark_r;
    region_valid_nxt = region_valid_r;
    if (op_r == pfa_pkg::OP_ALLOC) begin
      if (stacked_r != '0) begin
        got            = addr_r;
        stack_head_nxt = nf_q_r;
        stacked_nxt    = stacked_r - SW'(1);
        cnt_dec        = 1'b1;
      end else if (region_ne) begin
        got     = addr_r;
        cnt_dec = 1'b1;
        if (watermark_r == '0) begin
          region_valid_nxt = 1'b0;
        end else begin
          watermark_nxt = watermark_r - AW'(1);
        end
      end else begin
        sts = pfa_pkg::STS_OOM;
      end
      if (cnt_dec) begin
        meta_we_op    = 1'b1;
        meta_wdata_op = {1'b0, dl_lbl, RW'(0)};
        lab           = dl_lbl;
      end
    end else if (op_r > pfa_pkg::OP_SET_LABEL || pg_w >= NPAGES_W) begin
      sts = pfa_pkg::STS_BAD_ADDR;
    end else if (op_r == pfa_pkg::OP_FREE) begin
      if (pg_w < ke_w) begin
        sts = pfa_pkg::STS_BAD_ADDR;
      end else if (meta_freed || (region_ne && pg_w >= fs_w && pg_w <= wm_w)) begin
        sts = pfa_pkg::STS_DOUBLE_FREE;
        lab = meta_lab;
        rc  = meta_rc;
      end else begin
        meta_we_op    = 1'b1;
        meta_wdata_op = {1'b0, meta_lab, rc_dec};
        lab           = meta_lab;
        rc            = rc_dec;
        if (rc_dec == '0) begin
          meta_wdata_op  = {1'b1, meta_lab, rc_dec};
          nf_we_op       = 1'b1;
          stack_head_nxt = addr_r;
          stacked_nxt    = stacked_r + SW'(1);
          cnt_inc        = 1'b1;
        end
      end
    end else if (op_r == pfa_pkg::OP_INCREF) begin
      rc            = (meta_rc != pfa_pkg::RC_MAX) ? meta_rc + RW'(1) : meta_rc;
      lab           = meta_lab;
      meta_we_op    = 1'b1;
      meta_wdata_op = {meta_freed, meta_lab, rc};
    end else if (op_r == pfa_pkg::OP_SET_LABEL) begin
      lab           = nl_w[LABEL_BITS-1:0];
      rc            = meta_rc;
      meta_we_op    = 1'b1;
      meta_wdata_op = {meta_freed, lab, meta_rc};
    end else begin
      lab = meta_lab;
      rc  = meta_rc;
    end
  end

  assign meta_we    = (state_r == ST_CLEAR) || (exec_go && meta_we_op);
  assign meta_waddr = (state_r == ST_CLEAR) ? clr_addr_r : addr_r;
  assign meta_wdata = (state_r == ST_CLEAR) ? '0 : meta_wdata_op;
  assign nf_we      = exec_go && nf_we_op;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem_r[meta_waddr] <= meta_wdata;
    end
    meta_q_r <= meta_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (nf_we) begin
      nf_mem_r[addr_r] <= stack_head_r;
    end
    nf_q_r <= nf_mem_r[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_addr_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_EXEC;
      ST_EXEC:  if (exec_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_addr_r     <= '0;
      stack_head_r   <= '0;
      stacked_r      <= '0;
      watermark_r    <= LAST_ADDR;
      region_valid_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (exec_go) begin
        stack_head_r   <= stack_head_nxt;
        stacked_r      <= stacked_nxt;
        watermark_r    <= watermark_nxt;
        region_valid_r <= region_valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_ch.op;
      page_r <= in_ch.page;
      nl_r   <= in_ch.wr_label;
      addr_r <= rd_addr;
      cnt_r  <= cnt_before;
    end
  end

  assign cnt_after = cnt_r + CW'(cnt_inc) - CW'(cnt_dec);
  assign lab_w     = 32'(lab);
  assign got_w     = 16'(got);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status_r     <= sts;
      out_alloc_page_r <= got_w[pfa_pkg::FPAGE_W-1:0];
      out_label_r      <= lab_w[pfa_pkg::LBL_W-1:0];
      out_rc_r         <= rc;
      out_free_count_r <= (cnt_after > CNT_SAT) ? '1 : cnt_after[pfa_pkg::CNT_OUT_W-1:0];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.alloc_page    = out_alloc_page_r;
  assign out_ch.label_out     = out_label_r;
  assign out_ch.ref_count_out = out_rc_r;
  assign out_ch.free_count    = out_free_count_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_EXEC))
    else $error("request transfer not followed by execute");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stacked_r <= NPAGES_S)
    else $error("free stack deeper than page count");

  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("response raised outside execute");

  a_stack_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_EXEC) |=> ($stable(stacked_r) && $stable(stack_head_r)))
    else $error("free stack changed outside execute");

endmodule
